/* src/ulpf_pkg.sv */
package ulpf_pkg;

    localparam int unsigned SAMPLES_PER_PRB     = 12;
    localparam int unsigned SYMBOLS_PER_SLOT    = 14;
    localparam int unsigned SUBFRAMES_PER_FRAME = 10;
    localparam int unsigned MAX_NUMEROLOGY      = 4;

    localparam logic [1:0] REG_NUMEROLOGY       = 2'd0;
    localparam logic [1:0] REG_MAX_PRB          = 2'd1;
    localparam logic [1:0] REG_PRBS_PER_PACKET  = 2'd2;

    typedef struct packed {
        logic [2:0] numerology;
        logic [8:0] max_prb;
        logic [7:0] prbs_per_packet;
    } ulpf_cfg_t;

    typedef struct packed {
        logic [7:0] frame_count;
        logic [3:0] subframe_index;
        logic [5:0] slot_index;
        logic [3:0] symbol_index;
        logic [8:0] prb_position;
        logic [7:0] prb_in_packet;
        logic [3:0] sample_in_prb;
    } ulpf_pos_t;

    // words produced by one accepted sample
    typedef struct packed {
        logic        valid;
        logic        hdr;
        logic [31:0] hdr_word;
        logic [31:0] sec_word;
        logic [31:0] iq_word;
        logic        eop;
    } ulpf_push_t;

    typedef struct packed {
        logic [31:0] word;
        logic        eop;
        logic        last;
    } ulpf_entry_t;

endpackage

/* src/ulpf_ctrl.sv */
module ulpf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [31:0]         iq_sample,
    input  ulpf_pkg::ulpf_cfg_t cfg,
    output ulpf_pkg::ulpf_push_t push
);

    ulpf_pkg::ulpf_pos_t pos_reg;
    ulpf_pkg::ulpf_pos_t pos_next;
    ulpf_pkg::ulpf_pos_t cur;

    logic [8:0] mx;
    logic [7:0] ppp;
    logic [4:0] slots;
    logic [8:0] rem;
    logic [7:0] cnt;
    logic [9:0] pos_inc;
    logic [8:0] pip_inc;
    logic       eop;

    function automatic ulpf_pkg::ulpf_pos_t next_symbol(
        input ulpf_pkg::ulpf_pos_t s,
        input logic [4:0]          nslots
    );
        ulpf_pkg::ulpf_pos_t r;
        r = s;
        r.prb_position  = '0;
        r.prb_in_packet = '0;
        r.sample_in_prb = '0;
        if ((5'(s.symbol_index) + 5'd1) >= 5'(ulpf_pkg::SYMBOLS_PER_SLOT))
        begin
            r.symbol_index = '0;
            if ((7'(s.slot_index) + 7'd1) >= 7'(nslots))
            begin
                r.slot_index = '0;
                if ((5'(s.subframe_index) + 5'd1) >= 5'(ulpf_pkg::SUBFRAMES_PER_FRAME))
                begin
                    r.subframe_index = '0;
                    r.frame_count    = s.frame_count + 8'd1;
                end
                else
                begin
                    r.subframe_index = s.subframe_index + 4'd1;
                end
            end
            else
            begin
                r.slot_index = s.slot_index + 6'd1;
            end
        end
        else
        begin
            r.symbol_index = s.symbol_index + 4'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        mx    = (cfg.max_prb == '0) ? 9'd1 : cfg.max_prb;
        ppp   = (cfg.prbs_per_packet == '0) ? 8'd1 : cfg.prbs_per_packet;
        slots = (cfg.numerology > 3'(ulpf_pkg::MAX_NUMEROLOGY)) ?
                5'(5'd1 << ulpf_pkg::MAX_NUMEROLOGY) : 5'(5'd1 << cfg.numerology);

        // position left past the end after max_prb was lowered
        cur = pos_reg;
        if (pos_reg.prb_position >= mx)
        begin
            cur = next_symbol(pos_reg, slots);
        end

        rem = mx - cur.prb_position;
        cnt = (rem < {1'b0, ppp}) ? rem[7:0] : ppp;

        pos_inc  = 10'(cur.prb_position) + 10'd1;
        pip_inc  = 9'(cur.prb_in_packet) + 9'd1;
        eop      = 1'b0;
        pos_next = cur;
        if (cur.sample_in_prb >= 4'(ulpf_pkg::SAMPLES_PER_PRB - 1))
        begin
            pos_next.sample_in_prb = '0;
            if (pos_inc >= {1'b0, mx})
            begin
                eop      = 1'b1;
                pos_next = next_symbol(cur, slots);
            end
            else if (pip_inc >= {1'b0, ppp})
            begin
                eop                    = 1'b1;
                pos_next.prb_position  = pos_inc[8:0];
                pos_next.prb_in_packet = '0;
            end
            else
            begin
                pos_next.prb_position  = pos_inc[8:0];
                pos_next.prb_in_packet = pip_inc[7:0];
            end
        end
        else
        begin
            pos_next.sample_in_prb = cur.sample_in_prb + 4'd1;
        end

        push.valid    = accept;
        push.hdr      = (cur.prb_in_packet == '0) && (cur.sample_in_prb == '0);
        push.hdr_word = {8'h00, cur.frame_count, cur.subframe_index, cur.slot_index[5:2],
                         cur.slot_index[1:0], 2'b00, cur.symbol_index};
        push.sec_word = {8'h00, 7'b0, cur.prb_position[8], cur.prb_position[7:0], cnt};
        push.iq_word  = iq_sample;
        push.eop      = eop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

/* src/ulpf_outq.sv */
module ulpf_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ulpf_pkg::ulpf_push_t push,
    input  logic                 pop,
    output ulpf_pkg::ulpf_entry_t head,
    output logic [2:0]           level
);

    ulpf_pkg::ulpf_entry_t entry_reg [4];
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [2:0] push_n;

    always_comb
    begin
        push_n      = push.valid ? (push.hdr ? 3'd3 : 3'd1) : 3'd0;
        count_next  = count_reg + push_n - {2'b0, pop};
        wr_ptr_next = wr_ptr_reg + push_n[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            if (push.hdr)
            begin
                entry_reg[wr_ptr_reg]         <= '{word: push.hdr_word, eop: 1'b0, last: 1'b0};
                entry_reg[wr_ptr_reg + 2'd1]  <= '{word: push.sec_word, eop: 1'b0, last: 1'b0};
                entry_reg[wr_ptr_reg + 2'd2]  <= '{word: push.iq_word, eop: push.eop,
                                                   last: 1'b1};
            end
            else
            begin
                entry_reg[wr_ptr_reg] <= '{word: push.iq_word, eop: push.eop, last: 1'b1};
            end
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign level = count_reg;

endmodule

/* src/uplane_packet_framer.sv */
// a sample transfer writes its words into the registered output queue; out_valid is set in the cycle after it
// throughput: one sample per cycle inside a packet while in_stall is low; the first sample
// of a packet adds two header words, so three output transfers for that sample
// input stalls while more than one word waits in the four-entry output queue
// reset: all frame/slot/symbol/prb counters cleared, registers to defaults
module uplane_packet_framer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] iq_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_word,
    output logic        end_of_packet,
    output logic        last_of_run,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    ulpf_pkg::ulpf_cfg_t   cfg_reg;
    ulpf_pkg::ulpf_push_t  push;
    ulpf_pkg::ulpf_entry_t head;
    logic [2:0]            level;
    logic                  accept;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.numerology      <= 3'd0;
            cfg_reg.max_prb         <= 9'd273;
            cfg_reg.prbs_per_packet <= 8'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ulpf_pkg::REG_NUMEROLOGY:      cfg_reg.numerology      <= cfg_data[2:0];
                ulpf_pkg::REG_MAX_PRB:         cfg_reg.max_prb         <= cfg_data;
                ulpf_pkg::REG_PRBS_PER_PACKET: cfg_reg.prbs_per_packet <= cfg_data[7:0];
                default:                       cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // room for a header pair plus sample even if nothing drains
    assign in_stall  = (level > 3'd1);
    assign accept    = in_valid && !in_stall;
    assign out_valid = (level != 3'd0);
    assign pop       = out_valid && !out_stall;

    ulpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .iq_sample (iq_sample),
        .cfg       (cfg_reg),
        .push      (push)
    );

    ulpf_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .level (level)
    );

    assign out_word      = head.word;
    assign end_of_packet = head.eop;
    assign last_of_run   = head.last;

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= 3'd4)
        else $error("output queue overfilled");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("sample transfer left no word queued");

    a_eop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_packet) |-> last_of_run)
        else $error("end of packet on a header word");
`endif

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it, written once to see that it is ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SAMPLE_TARGET = 400;

    class uplane_word_predictor;
        bit [2:0] numerology;
        bit [8:0] max_prb;
        bit [7:0] prbs_per_packet;
        bit [7:0] frame_count;
        bit [3:0] subframe_index;
        bit [5:0] slot_index;
        bit [3:0] symbol_index;
        bit [8:0] prb_position;
        bit [7:0] prb_in_packet;
        bit [3:0] sample_in_prb;
        ulpf_pkg::ulpf_entry_t pending_words[$];
        int mismatches;
        int words_matched;
        int packets_closed;

        function void clear();
            numerology = 3'd0;
            max_prb = 9'd273;
            prbs_per_packet = 8'd16;
            frame_count = '0;
            subframe_index = '0;
            slot_index = '0;
            symbol_index = '0;
            prb_position = '0;
            prb_in_packet = '0;
            sample_in_prb = '0;
            pending_words.delete();
            mismatches = 0;
            words_matched = 0;
            packets_closed = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [8:0] val);
            case (idx)
                ulpf_pkg::REG_NUMEROLOGY:      numerology = val[2:0];
                ulpf_pkg::REG_MAX_PRB:         max_prb = val;
                ulpf_pkg::REG_PRBS_PER_PACKET: prbs_per_packet = val[7:0];
                default: ;
            endcase
        endfunction

        function int slots_per_subframe();
            return 1 << ((numerology > ulpf_pkg::MAX_NUMEROLOGY) ?
                         ulpf_pkg::MAX_NUMEROLOGY : numerology);
        endfunction

        function void advance_symbol();
            prb_position = '0;
            prb_in_packet = '0;
            sample_in_prb = '0;
            symbol_index++;
            if (symbol_index >= ulpf_pkg::SYMBOLS_PER_SLOT)
            begin
                symbol_index = '0;
                slot_index++;
                if (slot_index >= slots_per_subframe())
                begin
                    slot_index = '0;
                    subframe_index++;
                    if (subframe_index >= ulpf_pkg::SUBFRAMES_PER_FRAME)
                    begin
                        subframe_index = '0;
                        frame_count++;
                    end
                end
            end
        endfunction

        function void take_sample(logic [31:0] iq);
            int mx;
            int ppp;
            int cnt;
            ulpf_pkg::ulpf_entry_t e;
            logic eop;

            mx = (max_prb == 0) ? 1 : max_prb;
            ppp = (prbs_per_packet == 0) ? 1 : prbs_per_packet;
            // max_prb lowered under the current position: start the next symbol
            if (prb_position >= mx)
                advance_symbol();

            if (prb_in_packet == 0 && sample_in_prb == 0)
            begin
                cnt = mx - prb_position;
                if (cnt > ppp)
                    cnt = ppp;
                e.word = {8'h00, frame_count, subframe_index, slot_index[5:2],
                          slot_index[1:0], 2'b00, symbol_index};
                e.eop = 1'b0;
                e.last = 1'b0;
                pending_words = {pending_words, e};
                e.word = {8'h00, 7'd0, prb_position[8], prb_position[7:0], 8'(cnt)};
                pending_words = {pending_words, e};
            end

            eop = 1'b0;
            sample_in_prb++;
            if (sample_in_prb >= ulpf_pkg::SAMPLES_PER_PRB)
            begin
                sample_in_prb = '0;
                prb_position++;
                prb_in_packet++;
                if (prb_position >= mx)
                begin
                    eop = 1'b1;
                    advance_symbol();
                end
                else if (prb_in_packet >= ppp)
                begin
                    eop = 1'b1;
                    prb_in_packet = '0;
                end
            end
            e.word = iq;
            e.eop = eop;
            e.last = 1'b1;
            pending_words = {pending_words, e};
        endfunction

        function void match_word(logic [31:0] word, logic eop, logic last);
            ulpf_pkg::ulpf_entry_t e;

            if (pending_words.size() == 0)
            begin
                $error("out_word %h arrived with nothing expected", word);
                mismatches++;
                return;
            end
            e = pending_words.pop_front();
            words_matched++;
            if (eop === 1'b1)
                packets_closed++;
            if (word !== e.word)
            begin
                $error("out_word: expected %h, actual %h", e.word, word);
                mismatches++;
            end
            if (eop !== e.eop)
            begin
                $error("end_of_packet: expected %b, actual %b", e.eop, eop);
                mismatches++;
            end
            if (last !== e.last)
            begin
                $error("last_of_run: expected %b, actual %b", e.last, last);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] iq_sample;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_word;
    logic        end_of_packet;
    logic        last_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;

    uplane_word_predictor word_predictor;
    bit sender_quiet;
    int samples_sent;
    int reg_writes;

    uplane_packet_framer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .iq_sample     (iq_sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_word      (out_word),
        .end_of_packet (end_of_packet),
        .last_of_run   (last_of_run),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;

        if (sender_quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [31:0] pick_iq();
        int r;

        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        return $urandom;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic [31:0] iq);
        int gap;

        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        iq_sample <= iq;
        do
            @(posedge clk);
        while (in_stall);
        word_predictor.take_sample(iq);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (word_predictor.pending_words.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic run_samples(input int count);
        sender_quiet = ($urandom_range(0, 3) == 0);
        repeat (count) send_sample(pick_iq());
        end_burst();
    endtask

    // leaves cfg_valid high so back-to-back writes need no second assignment
    task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        word_predictor.write_reg(idx, val);
        reg_writes++;
        @(negedge clk);
    endtask

    task automatic random_settings();
        logic [8:0] v;
        int r;

        if ($urandom_range(0, 1) == 0)
        begin
            v = 9'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0)
                v = 9'($urandom_range(0, 511));
            write_reg(ulpf_pkg::REG_NUMEROLOGY, v);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                v = 9'($urandom_range(1, 6));
            else if (r < 70)
                v = 9'd0;
            else if (r < 82)
                v = 9'($urandom_range(7, 20));
            else if (r < 95)
                v = 9'($urandom_range(21, 273));
            else
                v = 9'($urandom_range(274, 511));
            write_reg(ulpf_pkg::REG_MAX_PRB, v);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                v = 9'($urandom_range(1, 4));
            else if (r < 70)
                v = 9'd0;
            else if (r < 90)
                v = 9'($urandom_range(5, 20));
            else
                v = 9'($urandom_range(21, 255));
            // bit 8 lies outside the register
            v[8] = 1'($urandom_range(0, 1));
            write_reg(ulpf_pkg::REG_PRBS_PER_PACKET, v);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic int pick_length();
        int r;

        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 30);
        if (r < 90)
            return $urandom_range(31, 80);
        return $urandom_range(81, 150);
    endfunction

    // receiver: runs of ready cycles broken by stalls, mostly short
    initial
    begin
        int hold;
        bit stalled;

        out_stall = 1'b0;
        hold = 0;
        stalled = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold == 0)
            begin
                stalled = !stalled;
                if (stalled)
                    hold = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 2) :
                           ($urandom_range(0, 99) < 75) ? $urandom_range(3, 6) :
                           $urandom_range(10, 30);
                else
                    hold = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) :
                           $urandom_range(20, 80);
            end
            out_stall <= stalled;
            hold--;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                word_predictor.match_word(out_word, end_of_packet, last_of_run);
        end
    end

    initial
    begin
        int idle_cycles;

        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        iq_sample = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples_sent = 0;
        reg_writes = 0;
        sender_quiet = 1'b1;
        word_predictor = new;
        word_predictor.clear();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, extreme words
        send_sample(32'h0000_0000);
        send_sample(32'hffff_ffff);
        send_sample(32'haaaa_aaaa);
        send_sample(32'h5555_5555);
        end_burst();

        // zero sizes and oversized numerology
        write_reg(ulpf_pkg::REG_MAX_PRB, 9'd0);
        write_reg(ulpf_pkg::REG_PRBS_PER_PACKET, 9'h100);
        write_reg(ulpf_pkg::REG_NUMEROLOGY, 9'h007);
        write_reg(REG_UNUSED, 9'h1ff);
        cfg_valid <= 1'b0;
        run_samples(12);

        // largest sizes: header count saturates at the packet size
        write_reg(ulpf_pkg::REG_MAX_PRB, 9'd511);
        write_reg(ulpf_pkg::REG_PRBS_PER_PACKET, 9'd255);
        write_reg(ulpf_pkg::REG_NUMEROLOGY, 9'd4);
        cfg_valid <= 1'b0;
        run_samples(4);

        // one-prb symbols: walk into slot 1, then shrink the slot count under it
        write_reg(ulpf_pkg::REG_MAX_PRB, 9'd1);
        write_reg(ulpf_pkg::REG_PRBS_PER_PACKET, 9'd1);
        write_reg(ulpf_pkg::REG_NUMEROLOGY, 9'd1);
        cfg_valid <= 1'b0;
        sender_quiet = 1'b0;
        while (word_predictor.slot_index == 0)
            send_sample(pick_iq());
        repeat (24) send_sample(pick_iq());
        end_burst();
        write_reg(ulpf_pkg::REG_NUMEROLOGY, 9'd0);
        cfg_valid <= 1'b0;
        while (word_predictor.slot_index != 0)
            send_sample(pick_iq());
        end_burst();

        while (samples_sent < SAMPLE_TARGET)
        begin
            random_settings();
            run_samples(pick_length());
        end

        wait_drained();
        repeat (10) @(negedge clk);

        $display("covered %0d samples, %0d output words, %0d packets, %0d register writes",
                 samples_sent, word_predictor.words_matched, word_predictor.packets_closed,
                 reg_writes);
        $display("stream ended at frame %0d subframe %0d slot %0d symbol %0d",
                 word_predictor.frame_count, word_predictor.subframe_index,
                 word_predictor.slot_index, word_predictor.symbol_index);
        if (word_predictor.mismatches == 0 && word_predictor.pending_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
